// ----- src/iapf_pkg.sv -----
// Package: request/result types, operation codes, status codes and width constants for the ALU.
`default_nettype none
package iapf_pkg;
  localparam int unsigned WIDTH_DEF = 32;
  localparam int unsigned FIELD_W   = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIVIDE = 4'd3, OP_DIV = 4'd4,
    OP_MOD = 4'd5, OP_LESS = 4'd6, OP_EQUAL = 4'd7, OP_AND = 4'd8, OP_OR = 4'd9,
    OP_NEG = 4'd10, OP_R11 = 4'd11, OP_R12 = 4'd12, OP_R13 = 4'd13, OP_R14 = 4'd14,
    OP_R15 = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_PROMOTE = 2'd1, ST_DIVZERO = 2'd2, ST_RSVD = 2'd3
  } status_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               promote_enable;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } res_t;
endpackage
`default_nettype wire

// ----- src/iapf_div.sv -----
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
`default_nettype none
module iapf_div #(
  parameter int unsigned W = iapf_pkg::WIDTH_DEF,
  parameter int unsigned TW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [W-1:0]  num,
  input  wire logic [W-1:0]  den,
  input  wire logic [TW-1:0] tag_in,
  output logic               out_valid,
  output logic [W-1:0]       quot,
  output logic [W-1:0]       rem,
  output logic [TW-1:0]      tag_out
);
  import iapf_pkg::*;

  logic           vld [W+1];
  logic [W-1:0]   rr [W+1];
  logic [W-1:0]   qq [W+1];
  logic [W-1:0]   dd [W+1];
  logic [TW-1:0]  tg [W+1];

  always_comb begin
    vld[0] = in_valid;
    rr[0]  = '0;
    qq[0]  = num;
    dd[0]  = den;
    tg[0]  = tag_in;
  end

  // each stage shifts in one numerator bit and tries one subtract
  for (genvar i = 0; i < W; i++) begin : g_stage
    logic [W:0] trial;
    logic [W:0] shifted;
    assign shifted = {rr[i], qq[i][W-1]};
    assign trial   = shifted - {1'b0, dd[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      if (trial[W]) begin
        rr[i+1] <= shifted[W-1:0];
      end else begin
        rr[i+1] <= trial[W-1:0];
      end
      qq[i+1] <= {qq[i][W-2:0], ~trial[W]};
      dd[i+1] <= dd[i];
      tg[i+1] <= tg[i];
    end
  end

  assign out_valid = vld[W];
  assign quot      = qq[W];
  assign rem       = rr[W];
  assign tag_out   = tg[W];
endmodule
`default_nettype wire

// ----- src/int_alu_with_promotion_flags.sv -----
// Top level: pipelined signed ALU with promotion and division-by-zero status.
//
//  channel  | ports                          | handshake
//  request  | start, busy, req (req_t)       | taken when start && !busy
//  result   | done, res (res_t)              | one cycle pulse, cannot stall
//
// Every request passes the capture stage, the operand stage, the divider
// (one quotient bit per stage) and the result register before its strobe,
// and all operations travel the same depth so results keep request order.
// One request is taken every cycle; busy is held low outside reset.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module int_alu_with_promotion_flags #(
  parameter int unsigned WIDTH = iapf_pkg::WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire iapf_pkg::req_t req,
  output logic               done,
  output iapf_pkg::res_t     res
);
  import iapf_pkg::*;

  localparam int unsigned LW = $clog2(WIDTH) + 1;
  localparam int unsigned SW = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;

  typedef struct packed {
    logic [3:0]     kind;
    logic           pe;
    logic           a_neg;
    logic           b_neg;
    logic           b_zero;
    logic           min_by_m1;
    logic [WIDTH-1:0] bm;
    logic [WIDTH-1:0] fast_v;
    logic [1:0]     fast_st;
  } tag_t;
  localparam int unsigned TW = $bits(tag_t);

  logic accept;
  assign busy   = rst;
  assign accept = start & ~busy;

  // Stage 1: operand capture, sign-extend then wrap to WIDTH
  logic             s1_v;
  logic [3:0]       s1_kind;
  logic             s1_pe;
  logic [WIDTH-1:0] s1_a, s1_b;
  logic [SW-1:0]    ext_a, ext_b;
  assign ext_a = SW'(signed'(req.operand_a));
  assign ext_b = SW'(signed'(req.operand_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept;
    end
    s1_kind <= req.kind;
    s1_pe   <= req.promote_enable;
    s1_a    <= ext_a[WIDTH-1:0];
    s1_b    <= ext_b[WIDTH-1:0];
  end

  // Stage 2: simple ops, magnitudes, floor-log2 for the multiply check
  function automatic logic [LW-1:0] flog2(input logic [WIDTH-1:0] m);
    logic [LW-1:0] n;
    n = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (m[i]) begin
        n = LW'(i);
      end
    end
    return n;
  endfunction

  logic             a_neg, b_neg;
  logic [WIDTH-1:0] am, bm, minw, sum, dif;
  logic [WIDTH-1:0] fv;
  logic [1:0]       fst;
  logic             mul_big;
  logic [LW:0]      lsum;

  always_comb begin
    minw  = {1'b1, {(WIDTH-1){1'b0}}};
    a_neg = s1_a[WIDTH-1];
    b_neg = s1_b[WIDTH-1];
    am    = a_neg ? -s1_a : s1_a;
    bm    = b_neg ? -s1_b : s1_b;
    sum   = s1_a + s1_b;
    dif   = s1_a - s1_b;
    lsum  = {1'b0, flog2(am)} + {1'b0, flog2(bm)};
    mul_big = lsum >= (LW+1)'(WIDTH - 2);
    fv  = '0;
    fst = ST_OK;
    unique case (op_t'(s1_kind))
      OP_ADD: begin
        fv = sum;
        if (s1_pe && a_neg == b_neg && sum[WIDTH-1] != a_neg) fst = ST_PROMOTE;
      end
      OP_SUB: begin
        fv = dif;
        if (s1_pe && a_neg != b_neg && dif[WIDTH-1] != a_neg) fst = ST_PROMOTE;
      end
      OP_MUL: begin
        if (s1_pe && mul_big) fst = ST_PROMOTE;
      end
      OP_LESS:  fv = WIDTH'($signed(s1_a) < $signed(s1_b));
      OP_EQUAL: fv = WIDTH'(s1_a == s1_b);
      OP_AND:   fv = s1_a & s1_b;
      OP_OR:    fv = s1_a | s1_b;
      OP_NEG: begin
        fv = -s1_a;
        if (s1_a == minw) fst = ST_PROMOTE;
      end
      default: begin
        fv  = '0;
        fst = ST_OK;
      end
    endcase
  end

  logic             s2_v;
  logic [WIDTH-1:0] s2_am;
  tag_t             s2_tag;
  logic [WIDTH-1:0] s2_ma, s2_mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_am            <= am;
    s2_ma            <= s1_a;
    s2_mb            <= s1_b;
    s2_tag.kind      <= s1_kind;
    s2_tag.pe        <= s1_pe;
    s2_tag.a_neg     <= a_neg;
    s2_tag.b_neg     <= b_neg;
    s2_tag.b_zero    <= (s1_b == '0);
    s2_tag.min_by_m1 <= (s1_a == minw) && (s1_b == '1);
    s2_tag.bm        <= bm;
    s2_tag.fast_v    <= fv;
    s2_tag.fast_st   <= fst;
  end

  // Multiply: one product register, then delay line matching the divider
  logic [WIDTH-1:0] mul_p;
  logic [WIDTH-1:0] mul_d [WIDTH];
  always_ff @(posedge clk) begin
    mul_p <= s2_ma * s2_mb;
  end
  always_comb begin
    mul_d[0] = mul_p;
  end
  for (genvar k = 0; k < WIDTH-1; k++) begin : g_mdly
    always_ff @(posedge clk) begin
      mul_d[k+1] <= mul_d[k];
    end
  end

  // Divider: a guarded zero divisor is replaced by one to keep it harmless
  logic             d_v;
  logic [WIDTH-1:0] d_q, d_r;
  logic [TW-1:0]    d_tag_bits;
  logic [WIDTH-1:0] den;
  assign den = s2_tag.b_zero ? WIDTH'(1) : s2_tag.bm;

  iapf_div #(.W(WIDTH), .TW(TW)) u_div (
    .clk(clk), .rst(rst), .in_valid(s2_v), .num(s2_am), .den(den),
    .tag_in(s2_tag), .out_valid(d_v), .quot(d_q), .rem(d_r),
    .tag_out(d_tag_bits)
  );

  // Final stage: apply signs, Euclidean correction and status merge
  tag_t             t;
  logic [WIDTH-1:0] q, v_fin;
  logic [1:0]       st_fin;
  logic             inexact;
  logic [WIDTH-1:0] mulv;
  assign mulv = mul_d[WIDTH-1];

  always_comb begin
    t       = tag_t'(d_tag_bits);
    inexact = (d_r != '0);
    q       = (t.a_neg != t.b_neg) ? -d_q : d_q;
    v_fin   = t.fast_v;
    st_fin  = t.fast_st;
    unique case (op_t'(t.kind))
      OP_MUL: v_fin = mulv;
      OP_DIVIDE, OP_DIV, OP_MOD: begin
        if (t.b_zero) begin
          v_fin  = '0;
          st_fin = ST_DIVZERO;
        end else begin
          st_fin = ST_OK;
          if (op_t'(t.kind) == OP_DIVIDE) begin
            v_fin = q;
            if (t.pe && inexact) st_fin = ST_PROMOTE;
          end else if (op_t'(t.kind) == OP_DIV) begin
            v_fin = q;
            if (t.a_neg && inexact) v_fin = t.b_neg ? q + WIDTH'(1) : q - WIDTH'(1);
          end else begin
            v_fin = (t.a_neg && inexact) ? t.bm - d_r : d_r;
          end
          if (op_t'(t.kind) != OP_MOD && t.pe && t.min_by_m1) st_fin = ST_PROMOTE;
        end
      end
      default: begin
        v_fin  = t.fast_v;
        st_fin = t.fast_st;
      end
    endcase
  end

  logic [SW-1:0] v_ext;
  assign v_ext = SW'(signed'(v_fin));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_v;
    end
    res.value  <= v_ext[FIELD_W-1:0];
    res.status <= st_fin;
  end

`ifndef NO_ASSERTIONS
  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised outside reset");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> res.status != ST_RSVD)
    else $error("reserved status produced");
  a_divzero_val: assert property (@(posedge clk) disable iff (rst)
    done && res.status == ST_DIVZERO |-> res.value == '0)
    else $error("division by zero with nonzero value");
  a_div_follows: assert property (@(posedge clk) disable iff (rst)
    d_v |=> done)
    else $error("divider result dropped");
`endif
endmodule
`default_nettype wire

// ----- tb/iapf_checker.sv -----
// Checker: watches the ALU request and result channels, predicts and compares results.
`timescale 1ns / 100ps
`default_nettype none
module iapf_checker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            busy,
  input  wire iapf_pkg::req_t  req,
  input  wire logic            done,
  input  wire iapf_pkg::res_t  res,
  output int                   fail_count,
  output int                   pending,
  output int                   requests_seen,
  output int                   results_seen
);
  import iapf_pkg::*;

  res_t expected_results[$];

  function automatic int unsigned floor_log2(logic [31:0] m);
    int unsigned n;
    n = 0;
    while (m > 1) begin
      m = m >> 1;
      n++;
    end
    return n;
  endfunction

  function automatic logic [31:0] magnitude(logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  // Compute the result for one request at WIDTH = 32.
  function automatic res_t alu_result(req_t r);
    res_t o;
    logic signed [31:0] a, b, v;
    logic [31:0] am, bm, qm, rm, q;
    a = r.operand_a;
    b = r.operand_b;
    v = '0;
    o.status = ST_OK;
    case (op_t'(r.kind))
      OP_ADD: begin
        v = a + b;
        if (r.promote_enable && a[31] == b[31] && v[31] != a[31]) o.status = ST_PROMOTE;
      end
      OP_SUB: begin
        v = a - b;
        if (r.promote_enable && a[31] != b[31] && v[31] != a[31]) o.status = ST_PROMOTE;
      end
      OP_MUL: begin
        v = a * b;
        if (r.promote_enable && floor_log2(magnitude(a)) + floor_log2(magnitude(b)) >= 30)
          o.status = ST_PROMOTE;
      end
      OP_DIVIDE, OP_DIV, OP_MOD: begin
        if (b == 0) begin
          v = '0;
          o.status = ST_DIVZERO;
        end else begin
          am = magnitude(a);
          bm = magnitude(b);
          qm = am / bm;
          rm = am % bm;
          q = (a[31] != b[31]) ? -qm : qm;
          if (op_t'(r.kind) == OP_DIVIDE) begin
            v = q;
            if (r.promote_enable && rm != 0) o.status = ST_PROMOTE;
          end else if (op_t'(r.kind) == OP_DIV) begin
            if (a[31] && rm != 0) q = b[31] ? q + 1 : q - 1;
            v = q;
          end else begin
            v = (a[31] && rm != 0) ? bm - rm : rm;
          end
          // minimum over minus one wraps back to the minimum
          if (op_t'(r.kind) != OP_MOD && r.promote_enable && a == 32'h8000_0000 &&
              b == -1)
            o.status = ST_PROMOTE;
        end
      end
      OP_LESS:  v = (a < b) ? 1 : 0;
      OP_EQUAL: v = (a == b) ? 1 : 0;
      OP_AND:   v = a & b;
      OP_OR:    v = a | b;
      OP_NEG: begin
        v = -a;
        if (a == 32'h8000_0000) o.status = ST_PROMOTE;
      end
      default: begin
        v = '0;
      end
    endcase
    o.value = v;
    return o;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      fail_count    <= 0;
      requests_seen <= 0;
      results_seen  <= 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(alu_result(req));
        requests_seen <= requests_seen + 1;
      end
      if (done) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result value=%h status=%0d",
                                        res.value, res.status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.value !== res.value || want.status !== res.status) begin
            if (fail_count < 10)
              $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                       want.value, want.status, res.value, res.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- tb/tb_int_alu_with_promotion_flags.sv -----
// Testbench top: drives requests into the ALU and gives the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_int_alu_with_promotion_flags;
  import iapf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req = '0;
  res_t res;
  int   fail_count, pending, requests_seen, results_seen;

  int_alu_with_promotion_flags i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res)
  );

  iapf_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done), .res(res),
    .fail_count(fail_count), .pending(pending), .requests_seen(requests_seen),
    .results_seen(results_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pick an operand biased towards the interesting corners.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'(signed'($urandom_range(0, 6)) - 3);
      4: return 32'(1) << $urandom_range(0, 31);
      5: return $urandom_range(0, 255);
      6: return -($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // Present one request from the falling edge and hold it until taken.
  task automatic send_request(op_t kind, logic [31:0] a, logic [31:0] b, logic pe);
    req <= '{kind: kind, operand_a: a, operand_b: b, promote_enable: pe};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    req   <= '{kind: op_t'($urandom_range(0, 15)), operand_a: $urandom,
               operand_b: $urandom, promote_enable: 1'($urandom_range(0, 1))};
    @(negedge clk);
  endtask

  localparam int RANDOM_REQUESTS = 1800;

  initial begin
    op_t k;
    int  wait_cycles;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every operation, the field extremes and the special cases.
    for (int op = 0; op < 16; op++) send_request(op_t'(op), 32'h8000_0000, 32'hffff_ffff, 1'b1);
    send_request(OP_ADD,    32'h7fff_ffff, 32'd1,         1'b1);
    send_request(OP_ADD,    32'h7fff_ffff, 32'd1,         1'b0);
    send_request(OP_SUB,    32'h8000_0000, 32'd1,         1'b1);
    send_request(OP_MUL,    32'h0001_0000, 32'h0000_4000, 1'b1);
    send_request(OP_MUL,    32'h8000_0000, 32'd0,         1'b1);
    send_request(OP_DIVIDE, 32'd7,         32'd2,         1'b1);
    send_request(OP_DIV,    32'hffff_fff9, 32'd2,         1'b0);
    send_request(OP_MOD,    32'hffff_fff9, 32'hffff_fffe, 1'b0);
    send_request(OP_DIV,    32'd5,         32'd0,         1'b1);
    send_request(OP_NEG,    32'h8000_0000, 32'd0,         1'b0);

    // Random: long stretch without gaps first, then gaps about 29 in 100.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n >= 300) while ($urandom_range(0, 99) < 29) idle_cycle();
      k = op_t'(($urandom_range(0, 19) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10));
      send_request(k, pick_operand(), pick_operand(), 1'($urandom_range(0, 1)));
    end
    start <= 1'b0;

    // Drain: wait for outstanding results, then let the pipeline run dry.
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    $display("Covered %0d requests over all operation codes, %0d results checked.",
             requests_seen, results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
